// ===== src/sparse_table_range_min_defines.svh =====
// Assertion macros for the sparse table range-minimum block.
`ifndef SPARSE_TABLE_RANGE_MIN_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SPTRM_ASSERT_NOW(LBL, CLK, RSTN, ANT, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CONS)) \
    else $error("sptrm: same-cycle check failed");
// Next-cycle implication, checked outside reset
`define SPTRM_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CONS)) \
    else $error("sptrm: next-cycle check failed");
`else
`define SPTRM_ASSERT_NOW(LBL, CLK, RSTN, ANT, CONS)
`define SPTRM_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CONS)
`endif

`endif

// ===== src/sptrm_pkg.sv =====
// Shared types, codes and helpers for the sparse table range-minimum block.
`timescale 1ns / 1ps
`default_nettype none

package sptrm_pkg;

  // Fixed field widths
  localparam int VAL_W    = 32;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int IN_IDX_W = 10;
  localparam int SPAN_W   = IN_IDX_W + 1;
  localparam int KW       = $clog2(SPAN_W);

  // Default sizing
  localparam int MAX_ELEMS_DEF = 1024;
  localparam int LEVELS_DEF    = 11;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_REPLY,
    OP_APPEND,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] status;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_APPEND,
    BK_QRD_A,
    BK_QRD_B,
    BK_QMIN,
    BK_EMIT
  } back_state_t;

  // Signed minimum of two words
  function automatic logic [VAL_W-1:0] smin(input logic signed [VAL_W-1:0] a,
                                             input logic signed [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== src/sptrm_front.sv =====
// Front end: accepts items, tracks the element count and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module sptrm_front
  import sptrm_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF,
  parameter int LEVELS    = LEVELS_DEF,
  localparam int IDX_W    = $clog2(MAX_ELEMS),
  localparam int LVL_W    = $clog2(LEVELS),
  localparam int ADDR_W   = LVL_W + IDX_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [IN_IDX_W-1:0]      in_left_index,
  input  logic [IN_IDX_W-1:0]      in_right_index,
  input  logic                     q_full,
  output logic                     push,
  output cmd_t                     push_cmd,
  output logic [VAL_W-1:0]         push_value,
  output logic [IDX_W-1:0]         push_pos,
  output logic [ADDR_W-1:0]        push_addr_a,
  output logic [ADDR_W-1:0]        push_addr_b
);

  localparam int CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int CW    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IN_IDX_W-1:0] lo, hi;
  logic [CW-1:0]       hi_w, cnt_w;
  logic [SPAN_W-1:0]   span, rstart;
  logic [KW-1:0]       k, kc;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Order the query ends and check against the count
  assign lo    = (in_left_index > in_right_index) ? in_right_index : in_left_index;
  assign hi    = (in_left_index > in_right_index) ? in_left_index : in_right_index;
  assign hi_w  = CW'(hi);
  assign cnt_w = CW'(count_r);

  // Block level from the leading one of the span, capped at the top level
  assign span = SPAN_W'(hi) - SPAN_W'(lo) + SPAN_W'(1);
  always_comb begin
    k = '0;
    for (int i = 0; i < SPAN_W; i++) begin
      if (span[i]) k = KW'(i);
    end
  end
  assign kc     = (int'(k) > LEVELS - 1) ? KW'(LEVELS - 1) : k;
  assign rstart = SPAN_W'(hi) + SPAN_W'(1) - (SPAN_W'(1) << kc);

  assign push_value  = in_value;
  assign push_pos    = IDX_W'(count_r);
  assign push_addr_a = {LVL_W'(kc), IDX_W'(lo)};
  assign push_addr_b = {LVL_W'(kc), IDX_W'(rstart)};

  // Classify the item
  always_comb begin
    count_nxt       = count_r;
    push_cmd.op     = OP_REPLY;
    push_cmd.status = STAT_OK;
    unique case (in_mode)
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      MODE_APPEND: begin
        if (count_r == CNT_W'(MAX_ELEMS)) begin
          push_cmd.status = STAT_FULL;
        end else begin
          push_cmd.op = OP_APPEND;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      MODE_QUERY: begin
        if (hi_w >= cnt_w) push_cmd.status = STAT_RANGE;
        else push_cmd.op = OP_QUERY;
      end
      default: begin
        push_cmd.op = OP_REPLY;
      end
    endcase
  end

  // Element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/sptrm_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module sptrm_queue
  import sptrm_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= din;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/sptrm_back.sv =====
// Back end: level table memory, append and query sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

module sptrm_back
  import sptrm_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF,
  parameter int LEVELS    = LEVELS_DEF,
  localparam int IDX_W    = $clog2(MAX_ELEMS),
  localparam int LVL_W    = $clog2(LEVELS),
  localparam int ADDR_W   = LVL_W + IDX_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     pop,
  input  cmd_t                     q_cmd,
  input  logic [VAL_W-1:0]         q_value,
  input  logic [IDX_W-1:0]         q_pos,
  input  logic [ADDR_W-1:0]        q_addr_a,
  input  logic [ADDR_W-1:0]        q_addr_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_min_value,
  output logic [STAT_W-1:0]        out_status
);

  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int CMP_W     = (CNT_W > LEVELS + 1) ? CNT_W : LEVELS + 1;
  localparam int MEM_DEPTH = LEVELS * (1 << IDX_W);

  back_state_t state_r, state_nxt;

  logic [VAL_W-1:0]  lvl_mem [MEM_DEPTH];
  logic [VAL_W-1:0]  rdata_r;

  logic [VAL_W-1:0]  val_r, cur_r, res_r;
  logic [IDX_W-1:0]  pos_r, start_r;
  logic [CMP_W-1:0]  p1_r, len_r;
  logic [ADDR_W-1:0] addr_a_r, addr_b_r;
  logic [STAT_W-1:0] status_r;
  logic [LVL_W-1:0]  lvl_r;
  logic              rd_pend_r, first_r;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_min_r;
  logic [STAT_W-1:0] out_status_r;

  logic              slot_free, emit;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0]  mem_wdata, pend_min;
  logic [CMP_W-1:0]  nlen;
  logic [IDX_W-1:0]  nstart;
  logic              can_issue;

  assign slot_free = !out_valid_r || out_ready;
  assign pend_min  = smin(rdata_r, cur_r);

  // Next block of the append: one level up, ending at the new element
  assign nlen      = len_r << 1;
  assign nstart    = IDX_W'(p1_r - nlen);
  assign can_issue = (lvl_r < LVL_W'(LEVELS - 1)) && (nlen <= p1_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            OP_APPEND: state_nxt = BK_APPEND;
            OP_QUERY:  state_nxt = BK_QRD_A;
            default:   state_nxt = BK_EMIT;
          endcase
        end
      end
      BK_APPEND: if (!can_issue) state_nxt = BK_EMIT;
      BK_QRD_A:  state_nxt = BK_QRD_B;
      BK_QRD_B:  state_nxt = BK_QMIN;
      BK_QMIN:   state_nxt = BK_EMIT;
      BK_EMIT:   if (slot_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {lvl_r, start_r};
    mem_wdata = pend_min;
    mem_raddr = {lvl_r, nstart};
    unique case (state_r)
      BK_IDLE: pop = !q_empty;
      BK_APPEND: begin
        if (first_r) begin
          mem_we    = 1'b1;
          mem_waddr = {LVL_W'(0), pos_r};
          mem_wdata = val_r;
        end else begin
          mem_we = rd_pend_r;
        end
        mem_re = can_issue;
      end
      BK_QRD_A: begin
        mem_re    = 1'b1;
        mem_raddr = addr_a_r;
      end
      BK_QRD_B: begin
        mem_re    = 1'b1;
        mem_raddr = addr_b_r;
      end
      BK_QMIN: pop = 1'b0;
      BK_EMIT: emit = slot_free;
      default: emit = 1'b0;
    endcase
  end

  // Level table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) lvl_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= lvl_mem[mem_raddr];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (pop) begin
            status_r  <= q_cmd.status;
            res_r     <= '0;
            val_r     <= q_value;
            pos_r     <= q_pos;
            p1_r      <= CMP_W'(q_pos) + CMP_W'(1);
            addr_a_r  <= q_addr_a;
            addr_b_r  <= q_addr_b;
            lvl_r     <= '0;
            len_r     <= CMP_W'(1);
            first_r   <= 1'b1;
            rd_pend_r <= 1'b0;
          end
        end
        BK_APPEND: begin
          // carry the newest block minimum up to the next level
          if (first_r) cur_r <= val_r;
          else if (rd_pend_r) cur_r <= pend_min;
          first_r <= 1'b0;
          if (can_issue) begin
            lvl_r     <= lvl_r + LVL_W'(1);
            len_r     <= nlen;
            start_r   <= nstart;
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
          end
        end
        BK_QRD_B: cur_r <= rdata_r;
        BK_QMIN:  res_r <= pend_min;
        default:  rd_pend_r <= rd_pend_r;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_min_r    <= res_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

// ===== src/sparse_table_range_min.sv =====
// Top level of the sparse table range-minimum engine.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   in_      | in_valid/in_ready   | mode, value, left_index, right_index
//   out_     | out_valid/out_ready | min_value, status
//
// A query passes through BK_QRD_A, BK_QRD_B and BK_QMIN to BK_EMIT; an append stays in
// BK_APPEND, filling one upper level per step; a clear or a rejected item goes to BK_EMIT.
// The single read port of the level table, one read a cycle, sets this sequence.
// A two-entry queue lets the front take items while the back end works.
// Reset clears the count, queue and sequencer; the table needs no clearing.
// A stalled result holds in the output register and stops the back end; once
// the queue also holds two items, in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_table_range_min_defines.svh"

module sparse_table_range_min
  import sptrm_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [IN_IDX_W-1:0]      in_left_index,
  input  logic [IN_IDX_W-1:0]      in_right_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_min_value,
  output logic [STAT_W-1:0]        out_status
);

  localparam int IDX_W  = $clog2(MAX_ELEMS);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int Q_W    = $bits(cmd_t) + VAL_W + IDX_W + 2 * ADDR_W;

  logic              push, pop, q_full, q_empty;
  cmd_t              push_cmd, q_cmd;
  logic [VAL_W-1:0]  push_value, q_value;
  logic [IDX_W-1:0]  push_pos, q_pos;
  logic [ADDR_W-1:0] push_addr_a, push_addr_b, q_addr_a, q_addr_b;
  logic [Q_W-1:0]    q_din, q_dout;

  sptrm_front #(
    .MAX_ELEMS (MAX_ELEMS),
    .LEVELS    (LEVELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd),
    .push_value     (push_value),
    .push_pos       (push_pos),
    .push_addr_a    (push_addr_a),
    .push_addr_b    (push_addr_b)
  );

  assign q_din = {push_cmd, push_value, push_pos, push_addr_a, push_addr_b};

  sptrm_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {q_cmd, q_value, q_pos, q_addr_a, q_addr_b} = q_dout;

  sptrm_back #(
    .MAX_ELEMS (MAX_ELEMS),
    .LEVELS    (LEVELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .pop           (pop),
    .q_cmd         (q_cmd),
    .q_value       (q_value),
    .q_pos         (q_pos),
    .q_addr_a      (q_addr_a),
    .q_addr_b      (q_addr_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_min_value (out_min_value),
    .out_status    (out_status)
  );

  // Back end only takes work that is really queued
  `SPTRM_ASSERT_NOW(a_pop_not_empty, clk, rst_n, pop, !q_empty)
  // Every item keeps the back end busy past the cycle it is taken
  `SPTRM_ASSERT_NEXT(a_no_double_pop, clk, rst_n, pop, !pop)
  // A full queue that is not drained refuses the next input
  `SPTRM_ASSERT_NEXT(a_full_blocks, clk, rst_n, q_full && !pop, !in_ready)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sparse table range-minimum engine.
`timescale 1ns / 1ps

module tb_top;
  import sptrm_pkg::*;

  localparam int MAX_ELEMS   = MAX_ELEMS_DEF;
  localparam int LEVELS      = LEVELS_DEF;
  localparam int N_ITEMS     = 1650;
  localparam int CALM_TAIL   = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 400000;
  localparam int PRINT_CAP   = 40;

  // Mode code the block leaves unused
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [VAL_W-1:0]  min_value;
    logic [STAT_W-1:0] status;
  } answer_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [VAL_W-1:0]    value;
    logic [IN_IDX_W-1:0] idx_a;
    logic [IN_IDX_W-1:0] idx_b;
    logic                typed;
    logic [VAL_W-1:0]    want_min;
    logic [STAT_W-1:0]   want_stat;
  } dir_row_t;

  // Directed rows; typed answers only where obvious, the rest go to the predictor
  localparam dir_row_t DIRECTED [0:22] = '{
    '{MODE_QUERY,  32'h0,        10'd0,    10'd0,    1'b1, 32'h0,        STAT_RANGE},
    '{MODE_SPARE,  32'hffffffff, 10'd1023, 10'd1023, 1'b1, 32'h0,        STAT_OK},
    '{MODE_APPEND, 32'h7fffffff, 10'd0,    10'd0,    1'b1, 32'h0,        STAT_OK},
    '{MODE_APPEND, 32'h80000000, 10'd1023, 10'd0,    1'b1, 32'h0,        STAT_OK},
    '{MODE_APPEND, 32'h00000000, 10'd0,    10'd1023, 1'b1, 32'h0,        STAT_OK},
    '{MODE_APPEND, 32'hffffffff, 10'd5,    10'd2,    1'b1, 32'h0,        STAT_OK},
    '{MODE_APPEND, 32'h00000005, 10'd0,    10'd0,    1'b1, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd0,    10'd0,    1'b1, 32'h7fffffff, STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd1,    10'd1,    1'b1, 32'h80000000, STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd3,    10'd2,    1'b0, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'hffffffff, 10'd4,    10'd0,    1'b1, 32'h80000000, STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd2,    10'd4,    1'b0, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd0,    10'd5,    1'b1, 32'h0,        STAT_RANGE},
    '{MODE_QUERY,  32'h0,        10'd1023, 10'd0,    1'b1, 32'h0,        STAT_RANGE},
    '{MODE_QUERY,  32'h0,        10'd1023, 10'd1023, 1'b1, 32'h0,        STAT_RANGE},
    '{MODE_APPEND, 32'h3fffffff, 10'd0,    10'd0,    1'b1, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd2,    10'd5,    1'b0, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd5,    10'd0,    1'b0, 32'h0,        STAT_OK},
    '{MODE_CLEAR,  32'h12345678, 10'd7,    10'd9,    1'b1, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd0,    10'd0,    1'b1, 32'h0,        STAT_RANGE},
    '{MODE_APPEND, 32'h12345678, 10'd0,    10'd0,    1'b1, 32'h0,        STAT_OK},
    '{MODE_QUERY,  32'h0,        10'd0,    10'd0,    1'b1, 32'h12345678, STAT_OK},
    '{MODE_SPARE,  32'h80000000, 10'd512,  10'd3,    1'b1, 32'h0,        STAT_OK}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [MODE_W-1:0] in_mode;
  logic signed [VAL_W-1:0] in_value;
  logic [IN_IDX_W-1:0] in_left_index;
  logic [IN_IDX_W-1:0] in_right_index;
  logic out_valid;
  logic out_ready;
  logic signed [VAL_W-1:0] out_min_value;
  logic [STAT_W-1:0] out_status;

  sparse_table_range_min uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_value  (out_min_value),
    .out_status     (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: loaded count and per-level block minima
  logic [VAL_W-1:0] block_min [0:LEVELS-1][0:MAX_ELEMS-1];
  int loaded;
  answer_t awaited_answers [$];

  int errors;
  int items_sent;
  int results_seen;
  int gap_pct;
  bit calm;
  bit reset_done;
  int n_append, n_full, n_query, n_range, n_clear, n_spare, deepest;
  longint cycle_cnt;

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("ERROR @%0t result %0d %s: got %h want %h", $time, results_seen, what, got,
               want);
  endtask

  function automatic logic [VAL_W-1:0] lesser(input logic signed [VAL_W-1:0] a,
                                              input logic signed [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Advance the predictor by one accepted item and return its answer
  task automatic predict_range_min(input logic [MODE_W-1:0] mode,
                                   input logic [VAL_W-1:0] value,
                                   input logic [IN_IDX_W-1:0] idx_a,
                                   input logic [IN_IDX_W-1:0] idx_b,
                                   output answer_t ans);
    int lo;
    int hi;
    int k;
    int pos;
    int rstart;
    ans.min_value = '0;
    ans.status    = STAT_OK;
    case (mode)
      MODE_CLEAR: begin
        loaded = 0;
        n_clear++;
      end
      MODE_APPEND: begin
        if (loaded >= MAX_ELEMS) begin
          ans.status = STAT_FULL;
          n_full++;
        end else begin
          pos = loaded;
          block_min[0][pos] = value;
          // each level's block that now ends at the new element
          for (k = 1; k < LEVELS && (1 << k) <= pos + 1; k++)
            block_min[k][pos + 1 - (1 << k)] =
              lesser(block_min[k-1][pos + 1 - (1 << k)],
                     block_min[k-1][pos + 1 - (1 << (k - 1))]);
          loaded = pos + 1;
          if (loaded > deepest) deepest = loaded;
          n_append++;
        end
      end
      MODE_QUERY: begin
        lo = (idx_a < idx_b) ? int'(idx_a) : int'(idx_b);
        hi = (idx_a < idx_b) ? int'(idx_b) : int'(idx_a);
        if (hi >= loaded) begin
          ans.status = STAT_RANGE;
          n_range++;
        end else begin
          k = 0;
          while (((hi - lo + 1) >> (k + 1)) != 0) k++;
          if (k > LEVELS - 1) k = LEVELS - 1;
          rstart = hi + 1 - (1 << k);
          ans.min_value = lesser(block_min[k][lo], block_min[k][rstart]);
          n_query++;
        end
      end
      default: n_spare++;
    endcase
  endtask

  // Offer one item, hold it until taken, then log its expected answer
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] value,
                           input logic [IN_IDX_W-1:0] idx_a,
                           input logic [IN_IDX_W-1:0] idx_b,
                           input logic typed, input logic [VAL_W-1:0] want_min,
                           input logic [STAT_W-1:0] want_stat);
    answer_t ans;
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_mode        = mode;
    in_value       = value;
    in_left_index  = idx_a;
    in_right_index = idx_b;
    do @(posedge clk); while (!in_ready);
    predict_range_min(mode, value, idx_a, idx_b, ans);
    if (typed) begin
      ans.min_value = want_min;
      ans.status    = want_stat;
    end
    awaited_answers.push_back(ans);
    items_sent++;
    if (items_sent >= N_ITEMS - CALM_TAIL) calm = 1'b1;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
  endtask

  // Append values: mostly full random, with extremes and a narrow band for ties
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Random index over the whole field
  function automatic logic [IN_IDX_W-1:0] rand_idx();
    return IN_IDX_W'($urandom);
  endfunction

  // One fill-and-probe sequence starting from a clear
  task automatic run_session(input int target, input int n_items, input int append_pct);
    int i;
    int r;
    int hi;
    int lo;
    send_item(MODE_CLEAR, $urandom, rand_idx(), rand_idx(), 1'b0, '0, STAT_OK);
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < append_pct && (loaded < target || target == MAX_ELEMS)) begin
        send_item(MODE_APPEND, pick_value(), rand_idx(), rand_idx(), 1'b0, '0, STAT_OK);
      end else if (r < 92 && loaded > 0) begin
        // well-formed query, short ranges favored half the time
        hi = $urandom_range(0, loaded - 1);
        if ($urandom_range(0, 1)) lo = $urandom_range(0, hi);
        else lo = (hi > 8) ? $urandom_range(hi - 8, hi) : $urandom_range(0, hi);
        if ($urandom_range(0, 1))
          send_item(MODE_QUERY, $urandom, IN_IDX_W'(lo), IN_IDX_W'(hi), 1'b0, '0, STAT_OK);
        else
          send_item(MODE_QUERY, $urandom, IN_IDX_W'(hi), IN_IDX_W'(lo), 1'b0, '0, STAT_OK);
      end else if (r < 96) begin
        send_item(MODE_QUERY, $urandom, rand_idx(), rand_idx(), 1'b0, '0, STAT_OK);
      end else if (r < 98 || target == MAX_ELEMS) begin
        send_item(MODE_SPARE, $urandom, rand_idx(), rand_idx(), 1'b0, '0, STAT_OK);
      end else begin
        send_item(MODE_CLEAR, $urandom, rand_idx(), rand_idx(), 1'b0, '0, STAT_OK);
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited_answers.size() == 0) begin
        report_mismatch("result with nothing pending", out_min_value, '0);
      end else begin
        want = awaited_answers.pop_front();
        if (out_min_value !== want.min_value)
          report_mismatch("min_value", out_min_value, want.min_value);
        if (out_status !== want.status)
          report_mismatch("status", VAL_W'(out_status), VAL_W'(want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               awaited_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off while items keep coming
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (reset_done);
    @(negedge clk);
    forever begin
      if (!held && items_sent >= 60) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int sess;
    int target;
    int i;
    in_valid       = 1'b0;
    in_mode        = MODE_CLEAR;
    in_value       = '0;
    in_left_index  = '0;
    in_right_index = '0;
    rst_n          = 1'b0;
    reset_done     = 1'b0;
    calm           = 1'b0;
    gap_pct        = 20;
    errors         = 0;
    items_sent     = 0;
    results_seen   = 0;
    loaded         = 0;
    cycle_cnt      = 0;
    {n_append, n_full, n_query, n_range, n_clear, n_spare, deepest} = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    reset_done = 1'b1;

    foreach (DIRECTED[j])
      send_item(DIRECTED[j].mode, DIRECTED[j].value, DIRECTED[j].idx_a, DIRECTED[j].idx_b,
                DIRECTED[j].typed, DIRECTED[j].want_min, DIRECTED[j].want_stat);
    wait_drained();

    sess = 0;
    while (items_sent < N_ITEMS) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (sess == 2) begin
        // one full load: fill to capacity, probe wide ranges, then overflow and clear
        run_session(MAX_ELEMS, 1150, 90);
        while (loaded < MAX_ELEMS)
          send_item(MODE_APPEND, pick_value(), rand_idx(), rand_idx(), 1'b0, '0, STAT_OK);
        for (i = 0; i < 3; i++)
          send_item(MODE_APPEND, pick_value(), rand_idx(), rand_idx(), 1'b1, '0, STAT_FULL);
        run_session(0, 0, 0);
        wait_drained();
      end else begin
        target = $urandom_range(1, 48);
        run_session(target, $urandom_range(20, 60), 45);
      end
      sess++;
    end
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    $display("%0d items: %0d appends, %0d full appends, %0d good queries, %0d rejected",
             items_sent, n_append, n_full, n_query, n_range);
    $display("%0d clears, %0d spare-mode items, deepest fill %0d, %0d results checked",
             n_clear, n_spare, deepest, results_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
